// ===== design/kttf_pkg.sv =====
// ----------------------------------------------------------------------------
// kttf_pkg
// Shared types, step codes and saturation helper for the tilt Kalman filter.
// ----------------------------------------------------------------------------
package kttf_pkg;

    localparam int SampleW  = 32;
    localparam int CovFrac  = 28;
    localparam int DtFrac   = 24;
    localparam int DtW      = 24;
    localparam int NoiseW   = 31;
    localparam int CfgIdxW  = 2;
    localparam int OpW      = 5;

    localparam logic [CfgIdxW-1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_MEAS_NOISE  = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_START_ANGLE = 2'd3;

    localparam logic [NoiseW-1:0] ANGLE_NOISE_RST = 31'd268435;
    localparam logic [NoiseW-1:0] BIAS_NOISE_RST  = 31'd805306;
    localparam logic [NoiseW-1:0] MEAS_NOISE_RST  = 31'd8053064;

    // datapath step sequence; each M_/W_ pair is a multiply then its write back
    localparam logic [OpW-1:0] OP_M_RATE = 5'd0;
    localparam logic [OpW-1:0] OP_W_ANG  = 5'd1;
    localparam logic [OpW-1:0] OP_M_T    = 5'd2;
    localparam logic [OpW-1:0] OP_W_T    = 5'd3;
    localparam logic [OpW-1:0] OP_M_B    = 5'd4;
    localparam logic [OpW-1:0] OP_W_B    = 5'd5;
    localparam logic [OpW-1:0] OP_M_A    = 5'd6;
    localparam logic [OpW-1:0] OP_W_A    = 5'd7;
    localparam logic [OpW-1:0] OP_S      = 5'd8;
    localparam logic [OpW-1:0] OP_Y      = 5'd9;
    localparam logic [OpW-1:0] OP_M_C0   = 5'd10;
    localparam logic [OpW-1:0] OP_W_C0   = 5'd11;
    localparam logic [OpW-1:0] OP_M_C1   = 5'd12;
    localparam logic [OpW-1:0] OP_W_C1   = 5'd13;
    localparam logic [OpW-1:0] OP_M_P10  = 5'd14;
    localparam logic [OpW-1:0] OP_W_P10  = 5'd15;
    localparam logic [OpW-1:0] OP_M_P00  = 5'd16;
    localparam logic [OpW-1:0] OP_W_P00  = 5'd17;
    localparam logic [OpW-1:0] OP_M_P11  = 5'd18;
    localparam logic [OpW-1:0] OP_W_P11  = 5'd19;
    localparam logic [OpW-1:0] OP_M_P01  = 5'd20;
    localparam logic [OpW-1:0] OP_W_P01  = 5'd21;

    typedef struct packed {
        logic           load;
        logic           run;
        logic [OpW-1:0] op;
        logic           div_start;
        logic           div_sel;
        logic           out_load;
    } kttf_cmd_t;

    typedef struct packed {
        logic s_pos;
        logic div_done;
    } kttf_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -68'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== design/kttf_div.sv =====
// ----------------------------------------------------------------------------
// kttf_div
// Restoring divider: saturated (num * 2^28) / den, truncated toward zero.
// ----------------------------------------------------------------------------
module kttf_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quotient
);
    import kttf_pkg::*;

    localparam int QW = 32 + CovFrac;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [32:0]   rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [31:0]   den_reg, den_next;
    logic          neg_reg, neg_next;
    logic [32:0]   rem_sh;
    logic [31:0]   mag;

    always_comb
    begin
        mag       = num[31] ? 32'(-33'(num)) : 32'(num);
        rem_sh    = {rem_reg[31:0], quo_reg[QW-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'(QW - 1);
            rem_next  = '0;
            quo_next  = {mag, {CovFrac{1'b0}}};
            den_next  = den;
            neg_next  = num[31];
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        if (!neg_reg)
            quotient = (quo_reg > QW'(32'h7fffffff)) ? 32'sh7fffffff : quo_reg[31:0];
        else
            quotient = (quo_reg > QW'(33'h080000000)) ? 32'sh80000000
                                                       : -quo_reg[31:0];
    end

    assign done = done_reg;

endmodule

// ===== design/kttf_datapath.sv =====
// ----------------------------------------------------------------------------
// kttf_datapath
// Filter state, config registers, shared multiplier and divider.
// ----------------------------------------------------------------------------
module kttf_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [kttf_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [31:0]                       cfg_data,
    input  logic signed [31:0]                measured_angle,
    input  logic signed [31:0]                measured_rate,
    input  logic [kttf_pkg::DtW-1:0]          time_step,
    input  kttf_pkg::kttf_cmd_t               cmd,
    output kttf_pkg::kttf_status_t            status,
    output logic signed [31:0]                filtered_angle,
    output logic signed [31:0]                unbiased_rate
);
    import kttf_pkg::*;

    logic [NoiseW-1:0]  apn_reg, bpn_reg, rn_reg;
    logic signed [31:0] ang_reg, bias_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] z_reg, rate_reg, t_reg, a_reg, s_reg, y_reg, k0_reg, k1_reg;
    logic [DtW-1:0]     dt_reg;
    logic signed [65:0] prod_reg;
    logic signed [31:0] fa_reg, ur_reg;

    logic signed [32:0] mul_a, mul_b, dt_s;
    logic signed [31:0] ps, s_val, div_q;
    logic               shift_dt, div_done;

    assign dt_s  = $signed({9'd0, dt_reg});
    assign s_val = sat32(68'(p00_reg) + 68'($signed({1'b0, rn_reg})));

    always_comb
    begin
        mul_a = 33'(rate_reg);
        mul_b = dt_s;
        unique case (cmd.op)
            OP_M_T:   mul_a = 33'(p11_reg);
            OP_M_B:   mul_a = $signed({2'b0, bpn_reg});
            OP_M_A:   mul_a = 33'(a_reg);
            OP_M_C0:
            begin
                mul_a = 33'(y_reg);
                mul_b = 33'(k0_reg);
            end
            OP_M_C1:
            begin
                mul_a = 33'(y_reg);
                mul_b = 33'(k1_reg);
            end
            OP_M_P10:
            begin
                mul_a = 33'(p00_reg);
                mul_b = 33'(k1_reg);
            end
            OP_M_P00:
            begin
                mul_a = 33'(p00_reg);
                mul_b = 33'(k0_reg);
            end
            OP_M_P11:
            begin
                mul_a = 33'(p01_reg);
                mul_b = 33'(k1_reg);
            end
            OP_M_P01:
            begin
                mul_a = 33'(p01_reg);
                mul_b = 33'(k0_reg);
            end
            default: ;
        endcase
    end

    assign shift_dt = (cmd.op == OP_W_ANG) || (cmd.op == OP_W_T) ||
                      (cmd.op == OP_W_B) || (cmd.op == OP_W_A);
    assign ps = shift_dt ? sat32(68'(prod_reg >>> DtFrac))
                         : sat32(68'(prod_reg >>> CovFrac));

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apn_reg  <= ANGLE_NOISE_RST;
            bpn_reg  <= BIAS_NOISE_RST;
            rn_reg   <= MEAS_NOISE_RST;
            ang_reg  <= '0;
            bias_reg <= '0;
            p00_reg  <= '0;
            p01_reg  <= '0;
            p10_reg  <= '0;
            p11_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ANGLE_NOISE: apn_reg <= cfg_data[NoiseW-1:0];
                    REG_BIAS_NOISE:  bpn_reg <= cfg_data[NoiseW-1:0];
                    REG_MEAS_NOISE:  rn_reg  <= cfg_data[NoiseW-1:0];
                    REG_START_ANGLE: ang_reg <= $signed(cfg_data);
                    default: ;
                endcase
            end
            if (cmd.run)
            begin
                case (cmd.op)
                    OP_W_ANG: ang_reg <= sat32(68'(ang_reg) + 68'(ps));
                    OP_W_B:
                    begin
                        p11_reg <= sat32(68'(p11_reg) + 68'(ps));
                        p01_reg <= sat32(68'(p01_reg) - 68'(t_reg));
                        p10_reg <= sat32(68'(p10_reg) - 68'(t_reg));
                    end
                    OP_W_A:   p00_reg  <= sat32(68'(p00_reg) + 68'(ps));
                    OP_W_C0:  ang_reg  <= sat32(68'(ang_reg) + 68'(ps));
                    OP_W_C1:  bias_reg <= sat32(68'(bias_reg) + 68'(ps));
                    OP_W_P10: p10_reg  <= sat32(68'(p10_reg) - 68'(ps));
                    OP_W_P00: p00_reg  <= sat32(68'(p00_reg) - 68'(ps));
                    OP_W_P11: p11_reg  <= sat32(68'(p11_reg) - 68'(ps));
                    OP_W_P01: p01_reg  <= sat32(68'(p01_reg) - 68'(ps));
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            z_reg    <= measured_angle;
            dt_reg   <= time_step;
            rate_reg <= sat32(68'(measured_rate) - 68'(bias_reg));
            k0_reg   <= '0;
            k1_reg   <= '0;
        end
        if (div_done)
        begin
            if (cmd.div_sel)
                k1_reg <= div_q;
            else
                k0_reg <= div_q;
        end
        if (cmd.run)
        begin
            case (cmd.op)
                OP_W_T: t_reg <= ps;
                OP_W_B: a_reg <= sat32(68'(t_reg) - 68'(p01_reg) - 68'(p10_reg)
                                       + 68'($signed({1'b0, apn_reg})));
                OP_S:   s_reg <= s_val;
                OP_Y:   y_reg <= sat32(68'(z_reg) - 68'(ang_reg));
                default: ;
            endcase
        end
        if (cmd.out_load)
        begin
            fa_reg <= ang_reg;
            ur_reg <= rate_reg;
        end
    end

    kttf_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (cmd.div_sel ? p10_reg : p00_reg),
        .den      (s_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign status.s_pos    = (s_val > 32'sd0);
    assign status.div_done = div_done;
    assign filtered_angle  = fa_reg;
    assign unbiased_rate   = ur_reg;

endmodule

// ===== design/kttf_ctrl.sv =====
// ----------------------------------------------------------------------------
// kttf_ctrl
// Sequencer: steps datapath, runs both gain divides if S > 0, hands off items.
// ----------------------------------------------------------------------------
module kttf_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  kttf_pkg::kttf_status_t status,
    output kttf_pkg::kttf_cmd_t    cmd
);
    import kttf_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;
    localparam logic [2:0] ST_D0S  = 3'd2;
    localparam logic [2:0] ST_D0W  = 3'd3;
    localparam logic [2:0] ST_D1S  = 3'd4;
    localparam logic [2:0] ST_D1W  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]     state_reg, state_next;
    logic [OpW-1:0] op_reg, op_next;
    logic           ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        in_stall   = 1'b1;
        ov_next    = ov_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    op_next    = OP_M_RATE;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.run = 1'b1;
                op_next = op_reg + 5'd1;
                if (op_reg == OP_S && status.s_pos)
                    state_next = ST_D0S;
                else if (op_reg == OP_W_P01)
                    state_next = ST_DONE;
            end
            ST_D0S:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_D0W;
            end
            ST_D0W:
            begin
                if (status.div_done)
                    state_next = ST_D1S;
            end
            ST_D1S:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = ST_D1W;
            end
            ST_D1W:
            begin
                cmd.div_sel = 1'b1;
                if (status.div_done)
                    state_next = ST_RUN;
            end
            ST_DONE:
            begin
                if (!(ov_reg && out_stall))
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_M_RATE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

endmodule

// ===== design/kalman_tilt_angle_filter_unit.sv =====
// ----------------------------------------------------------------------------
// kalman_tilt_angle_filter_unit
// Two-state (angle, gyro bias) Kalman filter fusing accel angle and gyro rate.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  in      | in_valid / in_stall      | measured_angle, measured_rate, time_step
//  out     | out_valid / out_stall    | filtered_angle, unbiased_rate
//  cfg     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
//  An item's time is set by the two serial gain divides (skipped when the
//  innovation variance is not positive) and 10 shared multiplies.
//  A finished item waits in the output register while the next one is taken.
//  Reset loads the default noises, zero covariance, bias and angle.
//  cfg_ready is always high; writes are expected only while idle.
module kalman_tilt_angle_filter_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [kttf_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [31:0]           measured_angle,
    input  logic signed [31:0]           measured_rate,
    input  logic [kttf_pkg::DtW-1:0]     time_step,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [31:0]           filtered_angle,
    output logic signed [31:0]           unbiased_rate
);
    import kttf_pkg::*;

    kttf_cmd_t    cmd;
    kttf_status_t status;

    assign cfg_ready = 1'b1;

    kttf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    kttf_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .measured_angle (measured_angle),
        .measured_rate  (measured_rate),
        .time_step      (time_step),
        .cmd            (cmd),
        .status         (status),
        .filtered_angle (filtered_angle),
        .unbiased_rate  (unbiased_rate)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while busy");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without an item in work");

    a_divide_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (in_stall && !cmd.run))
        else $error("divide started outside an item");

endmodule
